FILE: design/pfkp_pkg.sv
package pfkp_pkg;
  localparam int OFFSET_BITS_DEF = 16;

  localparam logic [3:0] PH_ETH   = 4'd0;
  localparam logic [3:0] PH_VLAN  = 4'd1;
  localparam logic [3:0] PH_IP    = 4'd2;
  localparam logic [3:0] PH_V4    = 4'd3;
  localparam logic [3:0] PH_V4OPT = 4'd4;
  localparam logic [3:0] PH_V6    = 4'd5;
  localparam logic [3:0] PH_EXT   = 4'd6;
  localparam logic [3:0] PH_L4    = 4'd7;
  localparam logic [3:0] PH_DONE  = 4'd8;
  localparam logic [3:0] PH_ERR   = 4'd9;

  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [15:0] ET_VLAN = 16'h8100;

  localparam logic [7:0] NH_HOP  = 8'd0;
  localparam logic [7:0] NH_TCP  = 8'd6;
  localparam logic [7:0] NH_UDP  = 8'd17;
  localparam logic [7:0] NH_RT   = 8'd43;
  localparam logic [7:0] NH_FRAG = 8'd44;
  localparam logic [7:0] NH_NONE = 8'd59;
  localparam logic [7:0] NH_DST  = 8'd60;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        parse_ok;
    logic        is_ipv6;
    logic        is_vlan;
    logic [7:0]  protocol;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        syn_seen;
  } out_t;
endpackage

FILE: design/pfkp_stream_if.sv
interface pfkp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/packet_flow_key_parser_core.sv
// A last byte's result goes to the output register, or to the skid stage on a stall.
// Throughput: one byte per cycle unless skid is full; per-byte state updates in one pass.
// Results hold in an output register and skid stage, so input stays ready while one waits.
// Reset: synchronous, active high; clears parse state and output valids.
module packet_flow_key_parser_core #(
  parameter int OFFSET_BITS = pfkp_pkg::OFFSET_BITS_DEF
) (
  input logic clk,
  input logic rst,
  pfkp_stream_if.sink   in_ch,
  pfkp_stream_if.source out_ch
);
  import pfkp_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam int SUM_BITS = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 1;

  logic [OFFSET_BITS-1:0] byte_offset, layer_start, ipv4_end;
  logic [3:0]  parse_phase;
  logic [15:0] type_field;
  logic [7:0]  next_header;
  logic [10:0] header_remaining;
  logic [63:0] src0, src1, dst0, dst1;
  logic [31:0] captured_ports;
  logic fl_vlan, fl_v6, fl_syn, fl_frag;

  logic [OFFSET_BITS-1:0] byte_offset_next, layer_start_next, ipv4_end_next;
  logic [3:0]  parse_phase_next;
  logic [15:0] type_field_next;
  logic [7:0]  next_header_next;
  logic [10:0] header_remaining_next;
  logic [63:0] src0_next, src1_next, dst0_next, dst1_next;
  logic [31:0] captured_ports_next;
  logic fl_vlan_next, fl_v6_next, fl_syn_next, fl_frag_next;

  logic out_valid, skid_valid;
  out_t out_reg, skid_reg, res;
  logic accept;

  logic [7:0] b;
  logic [OFFSET_BITS-1:0] pos, rel, pos1;
  logic [3:0] ph;
  logic [SUM_BITS-1:0] v4sum;
  logic [10:0] rem_dec;
  logic [7:0] nh_v6;
  logic l4;

  assign in_ch.ready = !skid_valid;
  assign accept = in_ch.valid && in_ch.ready;
  assign b = in_ch.payload.data_byte;
  assign pos = byte_offset;
  assign pos1 = pos + 1'b1;
  assign rel = pos - layer_start;
  assign v4sum = SUM_BITS'(layer_start) + SUM_BITS'(type_field_next);
  assign rem_dec = (header_remaining != 11'd0) ? header_remaining - 11'd1 : 11'd0;

  always_comb begin
    byte_offset_next = (byte_offset < OFF_MAX) ? pos1 : byte_offset;
    layer_start_next = layer_start;
    ipv4_end_next = ipv4_end;
    parse_phase_next = parse_phase;
    type_field_next = type_field;
    next_header_next = next_header;
    header_remaining_next = header_remaining;
    src0_next = src0;
    src1_next = src1;
    dst0_next = dst0;
    dst1_next = dst1;
    captured_ports_next = captured_ports;
    fl_vlan_next = fl_vlan;
    fl_v6_next = fl_v6;
    fl_syn_next = fl_syn;
    fl_frag_next = fl_frag;
    nh_v6 = 8'd0;
    ph = (parse_phase < PH_DONE && pos == OFF_MAX) ? PH_ERR : parse_phase;
    parse_phase_next = ph;
    case (ph)
      PH_ETH, PH_VLAN: begin
        if (rel == ((ph == PH_ETH) ? OFFSET_BITS'(12) : OFFSET_BITS'(2))) begin
          type_field_next = {b, 8'd0};
        end else if (rel == ((ph == PH_ETH) ? OFFSET_BITS'(13) : OFFSET_BITS'(3))) begin
          type_field_next = {type_field[15:8], b};
          layer_start_next = pos1;
          if (ph == PH_ETH && type_field_next == ET_VLAN) begin
            fl_vlan_next = 1'b1;
            parse_phase_next = PH_VLAN;
          end else begin
            parse_phase_next = (type_field_next == ET_IPV4 || type_field_next == ET_IPV6)
                               ? PH_IP : PH_ERR;
          end
        end
      end
      PH_IP: begin
        if (b[7:4] == 4'd4) begin
          header_remaining_next = {7'd0, b[3:0]};
          parse_phase_next = PH_V4;
        end else if (b[7:4] == 4'd6) begin
          fl_v6_next = 1'b1;
          parse_phase_next = PH_V6;
        end else begin
          parse_phase_next = PH_ERR;
        end
      end
      PH_V4: begin
        if (rel == OFFSET_BITS'(2)) begin
          type_field_next = {b, 8'd0};
        end else if (rel == OFFSET_BITS'(3)) begin
          type_field_next = {type_field[15:8], b};
          ipv4_end_next = (v4sum > SUM_BITS'(OFF_MAX)) ? OFF_MAX : v4sum[OFFSET_BITS-1:0];
        end else if (rel == OFFSET_BITS'(9)) begin
          next_header_next = b;
        end else if (rel >= OFFSET_BITS'(12) && rel <= OFFSET_BITS'(15)) begin
          src1_next = {src1[55:0], b};
        end else if (rel >= OFFSET_BITS'(16) && rel <= OFFSET_BITS'(19)) begin
          dst1_next = {dst1[55:0], b};
        end
        if (rel == OFFSET_BITS'(19)) begin
          if (header_remaining < 11'd5 ||
              {5'd0, header_remaining, 2'd0} > {2'd0, type_field}) begin
            parse_phase_next = PH_ERR;
          end else if (header_remaining == 11'd5) begin
            layer_start_next = pos1;
            parse_phase_next = (next_header == NH_TCP || next_header == NH_UDP)
                               ? PH_L4 : PH_DONE;
          end else begin
            header_remaining_next = {header_remaining[8:0], 2'd0} - 11'd20;
            parse_phase_next = PH_V4OPT;
          end
        end
      end
      PH_V4OPT: begin
        header_remaining_next = rem_dec;
        if (rem_dec == 11'd0) begin
          layer_start_next = pos1;
          parse_phase_next = (next_header == NH_TCP || next_header == NH_UDP)
                             ? PH_L4 : PH_DONE;
        end
      end
      PH_V6, PH_EXT: begin
        if (ph == PH_V6) begin
          if (rel == OFFSET_BITS'(6)) next_header_next = b;
          else if (rel >= OFFSET_BITS'(8) && rel <= OFFSET_BITS'(15))
            src0_next = {src0[55:0], b};
          else if (rel >= OFFSET_BITS'(16) && rel <= OFFSET_BITS'(23))
            src1_next = {src1[55:0], b};
          else if (rel >= OFFSET_BITS'(24) && rel <= OFFSET_BITS'(31))
            dst0_next = {dst0[55:0], b};
          else if (rel >= OFFSET_BITS'(32) && rel <= OFFSET_BITS'(39))
            dst1_next = {dst1[55:0], b};
        end else if (rel == OFFSET_BITS'(0)) begin
          next_header_next = b;
        end else if (rel == OFFSET_BITS'(1)) begin
          header_remaining_next = fl_frag ? 11'd6 : {b, 3'd0} + 11'd6;
        end else begin
          header_remaining_next = rem_dec;
        end
        if ((ph == PH_V6 && rel == OFFSET_BITS'(39)) ||
            (ph == PH_EXT && rel > OFFSET_BITS'(1) && rem_dec == 11'd0)) begin
          nh_v6 = next_header_next;
          layer_start_next = pos1;
          if (nh_v6 == NH_HOP || nh_v6 == NH_RT || nh_v6 == NH_DST) begin
            fl_frag_next = 1'b0;
            parse_phase_next = PH_EXT;
          end else if (nh_v6 == NH_FRAG) begin
            fl_frag_next = 1'b1;
            parse_phase_next = PH_EXT;
          end else if (nh_v6 == NH_NONE) begin
            parse_phase_next = PH_ERR;
          end else begin
            parse_phase_next = (nh_v6 == NH_TCP || nh_v6 == NH_UDP) ? PH_L4 : PH_DONE;
          end
        end
      end
      PH_L4: begin
        if (pos >= ipv4_end) begin
          parse_phase_next = PH_ERR;
        end else begin
          if (rel <= OFFSET_BITS'(3)) captured_ports_next = {captured_ports[23:0], b};
          if (next_header == NH_TCP && rel == OFFSET_BITS'(13) && b[1]) fl_syn_next = 1'b1;
          if (rel == ((next_header == NH_TCP) ? OFFSET_BITS'(19) : OFFSET_BITS'(7)))
            parse_phase_next = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    l4 = (next_header_next == NH_TCP || next_header_next == NH_UDP);
    res = '0;
    if (parse_phase_next == PH_DONE) begin
      res.parse_ok = 1'b1;
      res.is_ipv6 = fl_v6_next;
      res.is_vlan = fl_vlan_next;
      res.protocol = l4 ? next_header_next : 8'd0;
      res.src_addr_high = src0_next;
      res.src_addr_low = src1_next;
      res.dst_addr_high = dst0_next;
      res.dst_addr_low = dst1_next;
      res.src_port = l4 ? captured_ports_next[31:16] : 16'd0;
      res.dst_port = l4 ? captured_ports_next[15:0] : 16'd0;
      res.syn_seen = (next_header_next == NH_TCP) && fl_syn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.payload.last_byte)) begin
      byte_offset <= '0;
      layer_start <= '0;
      ipv4_end <= OFF_MAX;
      parse_phase <= PH_ETH;
      type_field <= '0;
      next_header <= '0;
      header_remaining <= '0;
      src0 <= '0;
      src1 <= '0;
      dst0 <= '0;
      dst1 <= '0;
      captured_ports <= '0;
      fl_vlan <= 1'b0;
      fl_v6 <= 1'b0;
      fl_syn <= 1'b0;
      fl_frag <= 1'b0;
    end else if (accept) begin
      byte_offset <= byte_offset_next;
      layer_start <= layer_start_next;
      ipv4_end <= ipv4_end_next;
      parse_phase <= parse_phase_next;
      type_field <= type_field_next;
      next_header <= next_header_next;
      header_remaining <= header_remaining_next;
      src0 <= src0_next;
      src1 <= src1_next;
      dst0 <= dst0_next;
      dst1 <= dst1_next;
      captured_ports <= captured_ports_next;
      fl_vlan <= fl_vlan_next;
      fl_v6 <= fl_v6_next;
      fl_syn <= fl_syn_next;
      fl_frag <= fl_frag_next;
    end
  end

  logic push;
  assign push = accept && in_ch.payload.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ch.ready) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          out_reg <= skid_reg;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
          if (push) out_reg <= res;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
        skid_reg <= res;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.payload = out_reg;
endmodule

FILE: design/pfkp_checker.sv
module pfkp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input pfkp_pkg::out_t out_payload
);
  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload.parse_ok |-> out_payload.protocol == 8'd0 &&
      out_payload.src_port == 16'd0 && !out_payload.syn_seen && !out_payload.is_ipv6)
    else $error("error result carries nonzero fields");
  a_syn_tcp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.syn_seen |-> out_payload.protocol == 8'd6)
    else $error("syn without tcp");
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready && in_last) |=> !out_valid)
    else $error("result without last byte");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");
endmodule

bind packet_flow_key_parser_core pfkp_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.payload.last_byte),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
